// ===== design/tes_pkg.sv =====
// threshold event sequencer package: state codes, position ordering and helpers
// shared by the controller and datapath; no dependencies
`default_nettype none

package tes_pkg;

	// event state codes as they arrive on the input
	localparam logic [7:0] CODE_NORMAL     = 8'd1;
	localparam logic [7:0] CODE_LOW_WARN   = 8'd5;
	localparam logic [7:0] CODE_LOW_CRIT   = 8'd6;
	localparam logic [7:0] CODE_LOW_FATAL  = 8'd7;
	localparam logic [7:0] CODE_HIGH_WARN  = 8'd8;
	localparam logic [7:0] CODE_HIGH_CRIT  = 8'd9;
	localparam logic [7:0] CODE_HIGH_FATAL = 8'd10;

	// ordered position, 0 lower fatal .. 6 upper fatal
	typedef logic [2:0] pos_t;
	localparam pos_t NORMAL_POS = 3'd3;

	typedef struct packed {
		logic known;
		pos_t pos;
	} spos_t;

	typedef struct packed {
		logic load;
		logic step;
	} tes_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_item;
	} tes_stat_t;

	function automatic spos_t state_pos(input logic [7:0] code);
		spos_t r;
		r.known = 1'b1;
		case (code)
			CODE_LOW_FATAL:  r.pos = 3'd0;
			CODE_LOW_CRIT:   r.pos = 3'd1;
			CODE_LOW_WARN:   r.pos = 3'd2;
			CODE_NORMAL:     r.pos = NORMAL_POS;
			CODE_HIGH_WARN:  r.pos = 3'd4;
			CODE_HIGH_CRIT:  r.pos = 3'd5;
			CODE_HIGH_FATAL: r.pos = 3'd6;
			default: begin
				r.known = 1'b0;
				r.pos   = NORMAL_POS;
			end
		endcase
		return r;
	endfunction

	// alarm level: distance from normal minus one
	function automatic logic [1:0] level_of(input pos_t p);
		pos_t d;
		if (p > NORMAL_POS) begin
			d = p - (NORMAL_POS + 3'd1);
		end else begin
			d = (NORMAL_POS - 3'd1) - p;
		end
		return d[1:0];
	endfunction

	// first position that emits in a walk; a walk out of normal skips normal
	function automatic pos_t seg_start(input pos_t sp, input pos_t sn);
		pos_t r;
		r = sp;
		if (sp == NORMAL_POS) begin
			r = (sn > sp) ? sp + 3'd1 : sp - 3'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/tes_if.sv =====
// channel interfaces for the threshold event sequencer: sensor transitions in,
// alarm beats out; no dependencies
`default_nettype none

interface tes_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  previous_state;
	logic [7:0]  next_state;
	logic [31:0] reading;

	modport source (output valid, output previous_state, output next_state, output reading,
		input ready);
	modport sink (input valid, input previous_state, input next_state, input reading,
		output ready);
endinterface

interface tes_out_if;
	logic        valid;
	logic        ready;
	logic        has_event;
	logic [1:0]  level;
	logic        direction;
	logic        asserted;
	logic        status;
	logic        last;
	logic [31:0] reading_out;

	modport source (output valid, output has_event, output level, output direction,
		output asserted, output status, output last, output reading_out, input ready);
	modport sink (input valid, input has_event, input level, input direction,
		input asserted, input status, input last, input reading_out, output ready);
endinterface

`default_nettype wire

// ===== design/tes_datapath.sv =====
// threshold event sequencer datapath: walk registers, event generation and
// output register; depends on tes_pkg
`default_nettype none

module tes_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       previous_state,
	input  wire logic [7:0]       next_state,
	input  wire logic [31:0]      reading,
	input  wire tes_pkg::tes_cmd_t  cmd,
	output tes_pkg::tes_stat_t      stat,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  out_has_event,
	output logic [1:0]            out_level,
	output logic                  out_direction,
	output logic                  out_asserted,
	output logic                  out_status,
	output logic                  out_last,
	output logic [31:0]           out_reading
);
	import tes_pkg::*;

	// walk state
	pos_t        seg_sp_q, seg_sn_q, cur_q, fin_n_q;
	logic        sub_q, cross_q, special_q, err_q;
	logic [31:0] reading_q;

	// output register
	logic        out_valid_q;
	logic        has_q, dir_q, asrt_q, status_q, last_q;
	logic [1:0]  level_q;
	logic [31:0] rdg_q;

	// load decode
	spos_t p_in, n_in;
	logic  ld_err, ld_cross;
	pos_t  ld_sn;

	// step logic
	logic  up, better, at_end, seg_done;
	pos_t  nxt, e_pos, cur_d, sp_d, sn_d;
	logic  e_has, e_asrt, e_last, sub_d, cross_d;

	always_comb begin
		p_in     = state_pos(previous_state);
		n_in     = state_pos(next_state);
		ld_err   = !p_in.known || !n_in.known;
		ld_cross = (p_in.pos < NORMAL_POS && n_in.pos > NORMAL_POS) ||
			(p_in.pos > NORMAL_POS && n_in.pos < NORMAL_POS);
		ld_sn    = ld_cross ? NORMAL_POS : n_in.pos;
	end

	always_comb begin
		up     = seg_sp_q < seg_sn_q;
		better = (up && seg_sp_q < NORMAL_POS) || (!up && seg_sp_q > NORMAL_POS);
		nxt    = up ? cur_q + 3'd1 : cur_q - 3'd1;
		at_end = cur_q == seg_sn_q;

		e_has    = !special_q;
		e_pos    = cur_q;
		e_asrt   = 1'b1;
		seg_done = 1'b0;
		sub_d    = 1'b0;
		cur_d    = cur_q;
		sp_d     = seg_sp_q;
		sn_d     = seg_sn_q;
		cross_d  = cross_q;

		if (at_end) begin
			// target level asserted last
			seg_done = 1'b1;
		end else if (better && cur_q != seg_sp_q && !sub_q) begin
			// re-assert before deasserting a passed level
			sub_d = 1'b1;
		end else begin
			e_asrt   = !better;
			cur_d    = nxt;
			seg_done = (nxt == seg_sn_q) && (seg_sn_q == NORMAL_POS);
		end

		e_last = special_q || (seg_done && !cross_q);
		if (seg_done && cross_q) begin
			// second half: normal to target
			sp_d    = NORMAL_POS;
			sn_d    = fin_n_q;
			cur_d   = seg_start(NORMAL_POS, fin_n_q);
			sub_d   = 1'b0;
			cross_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seg_sp_q  <= p_in.pos;
			seg_sn_q  <= ld_sn;
			cur_q     <= seg_start(p_in.pos, ld_sn);
			fin_n_q   <= n_in.pos;
			sub_q     <= 1'b0;
			cross_q   <= ld_cross;
			err_q     <= ld_err;
			special_q <= ld_err || (p_in.pos == n_in.pos);
			reading_q <= reading;
		end else if (cmd.step) begin
			seg_sp_q <= sp_d;
			seg_sn_q <= sn_d;
			cur_q    <= cur_d;
			sub_q    <= sub_d;
			cross_q  <= cross_d;
		end
		if (cmd.step) begin
			has_q    <= e_has;
			level_q  <= e_has ? level_of(e_pos) : 2'd0;
			dir_q    <= e_has && (e_pos > NORMAL_POS);
			asrt_q   <= e_has && e_asrt;
			status_q <= special_q && err_q;
			last_q   <= e_last;
			rdg_q    <= e_has ? reading_q : 32'd0;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.last_item = e_last;

	assign out_valid     = out_valid_q;
	assign out_has_event = has_q;
	assign out_level     = level_q;
	assign out_direction = dir_q;
	assign out_asserted  = asrt_q;
	assign out_status    = status_q;
	assign out_last      = last_q;
	assign out_reading   = rdg_q;

	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!out_valid_q || out_ready))
		else $error("step issued while output register is blocked");
	a_special_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && special_q |=> out_valid_q && last_q && !has_q)
		else $error("special item not issued as a single last beat");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && has_q |-> level_q != 2'd3)
		else $error("alarm level out of range");
endmodule

`default_nettype wire

// ===== design/tes_ctrl.sv =====
// threshold event sequencer controller: idle/run state machine that loads a
// transition and steps the datapath once per beat; depends on tes_pkg
`default_nettype none

module tes_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tes_pkg::tes_stat_t stat,
	output tes_pkg::tes_cmd_t       cmd
);
	import tes_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.step = 1'b1;
					if (stat.last_item) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in the same cycle");
	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("load did not start a run");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && stat.last_item |=> state_q == ST_IDLE)
		else $error("run continued past the last beat");
endmodule

`default_nettype wire

// ===== design/threshold_event_sequencer.sv =====
// threshold event sequencer: one transition in, one to eight alarm beats out
// a transition is loaded while idle, then one beat per cycle enters the output
// register while it is free; k = 1..8 beats per transition (8 worst case,
// lower fatal to upper fatal), set by the walk registers stepping once
// per beat; a stall on the alarm side holds the step
// reset: arst_n clears the controller to idle and empties the output register
`default_nettype none

module threshold_event_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	tes_in_if.sink   sensor,
	tes_out_if.source alarm
);
	import tes_pkg::*;

	// command and status between controller and datapath
	tes_cmd_t  cmd;
	tes_stat_t stat;

	// controller: idle waits for a transition, run issues one beat per free
	// output slot until the datapath flags the last beat
	tes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sensor.valid),
		.in_ready (sensor.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: decodes codes to positions, walks the levels and holds the
	// result beat; the next transition is taken while the last beat waits
	tes_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.previous_state (sensor.previous_state),
		.next_state     (sensor.next_state),
		.reading        (sensor.reading),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (alarm.ready),
		.out_valid      (alarm.valid),
		.out_has_event  (alarm.has_event),
		.out_level      (alarm.level),
		.out_direction  (alarm.direction),
		.out_asserted   (alarm.asserted),
		.out_status     (alarm.status),
		.out_last       (alarm.last),
		.out_reading    (alarm.reading_out)
	);
endmodule

`default_nettype wire
